[hdl/button_debounce_click_classifier_macros.svh]
// ----------------------------------------------------------------------------
// Button debounce click classifier assertion macros
// Shared macros for the concurrent checks of the classifier; defining
// NO_ASSERTIONS compiles every check away.
// ----------------------------------------------------------------------------
`ifndef BUTTON_DEBOUNCE_CLICK_CLASSIFIER_MACROS_SVH
`define BUTTON_DEBOUNCE_CLICK_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and held off while in reset.
`define BDCC_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bdcc same-cycle check failed");
// Next-cycle implication, sampled on clk and held off while in reset.
`define BDCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bdcc next-cycle check failed");
`else
`define BDCC_ASSERT_NOW(label, ante, cons)
`define BDCC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hdl/bdcc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce click classifier package
// Register indexes, reset values and the configuration bundle type.
// ----------------------------------------------------------------------------
package bdcc_pkg;

	// Width of the configuration write data and index.
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT_LIMIT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_WIN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLICKS_NEED = 3'd4;

	// Register reset values.
	localparam logic [7:0]  DEBOUNCE_RST    = 8'd50;
	localparam logic [15:0] SHORT_LIMIT_RST = 16'd1000;
	localparam logic [15:0] CLICK_WIN_RST   = 16'd600;
	localparam logic [15:0] LONG_PRESS_RST  = 16'd5000;
	localparam logic [3:0]  CLICKS_NEED_RST = 4'd3;

	// Largest click count.
	localparam logic [3:0] CLICKS_MAX = 4'd15;

	// Configuration bundle handed from the register file to the datapath.
	typedef struct packed {
		logic [7:0]  debounce_ms;
		logic [15:0] short_press_limit_ms;
		logic [15:0] click_window_ms;
		logic [15:0] long_press_ms;
		logic [3:0]  clicks_needed;
	} cfg_t;

endpackage

[hdl/bdcc_cfg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce click classifier configuration registers
// Write-only register file; unknown indexes are ignored.
// ----------------------------------------------------------------------------
module bdcc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [bdcc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bdcc_pkg::CFG_DATA_W-1:0]    cfg_data,
	output bdcc_pkg::cfg_t                     cfg
);

	bdcc_pkg::cfg_t cfg_q;

	// Register writes, decoded by index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms          <= bdcc_pkg::DEBOUNCE_RST;
			cfg_q.short_press_limit_ms <= bdcc_pkg::SHORT_LIMIT_RST;
			cfg_q.click_window_ms      <= bdcc_pkg::CLICK_WIN_RST;
			cfg_q.long_press_ms        <= bdcc_pkg::LONG_PRESS_RST;
			cfg_q.clicks_needed        <= bdcc_pkg::CLICKS_NEED_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bdcc_pkg::REG_DEBOUNCE:    cfg_q.debounce_ms          <= cfg_data[7:0];
				bdcc_pkg::REG_SHORT_LIMIT: cfg_q.short_press_limit_ms <= cfg_data[15:0];
				bdcc_pkg::REG_CLICK_WIN:   cfg_q.click_window_ms      <= cfg_data[15:0];
				bdcc_pkg::REG_LONG_PRESS:  cfg_q.long_press_ms        <= cfg_data[15:0];
				bdcc_pkg::REG_CLICKS_NEED: cfg_q.clicks_needed        <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[hdl/button_debounce_click_classifier.sv]
// ----------------------------------------------------------------------------
// Button debounce click classifier
// Each transaction on the input channel is one millisecond tick carrying the
// raw active-low button level; each tick gives exactly one result with the
// debounced state, hold time, release, long-press and multi-click pulses.
// One tick is taken every clock cycle while the input channel is not stalled. A
// tick goes into an input register and its result is written to the output
// register when the input register advances. The rate is set by the single
// per-tick update of the timer and click state. The input channel stalls only
// while both the input register and the output register are full and the
// output is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "button_debounce_click_classifier_macros.svh"

module button_debounce_click_classifier #(
	parameter int TIMER_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration port.
	input  logic                                 cfg_we,
	input  logic [bdcc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bdcc_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Input channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 pin_level,
	// Output channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic                                 pressed,
	output logic [15:0]                          held_ms,
	output logic                                 release_event,
	output logic [15:0]                          release_held_ms,
	output logic                                 long_press,
	output logic                                 multi_click,
	output logic [3:0]                           click_count
);

	// Compare width: timers and 16-bit limits meet at the wider of the two.
	localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;

	bdcc_pkg::cfg_t cfg;

	bdcc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Handshake control.
	logic valid_s1;
	logic level_s1;
	logic out_valid_q;
	logic adv_s1;
	logic in_acc;

	assign adv_s1   = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;
	assign in_acc   = in_valid && !in_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			level_s1 <= pin_level;
		end
	end

	// Classifier state.
	logic                  stable_q;
	logic [TIMER_BITS-1:0] since_change_q;
	logic [TIMER_BITS-1:0] hold_q;
	logic [TIMER_BITS-1:0] last_hold_q;
	logic [TIMER_BITS-1:0] since_click_q;
	logic [3:0]            clicks_q;
	logic                  long_done_q;

	// Next-state values for the tick in the input register.
	logic                  stable_nx;
	logic [TIMER_BITS-1:0] since_change_nx;
	logic [TIMER_BITS-1:0] hold_nx;
	logic [TIMER_BITS-1:0] last_hold_nx;
	logic [TIMER_BITS-1:0] since_click_nx;
	logic [3:0]            clicks_nx;
	logic                  long_done_nx;
	logic                  rel_nx;
	logic                  lp_nx;
	logic                  mc_nx;
	logic [3:0]            need;
	logic [CW-1:0]         sc_inc_ext;
	logic [CW-1:0]         ck_inc_ext;
	logic [CW-1:0]         hold_ext;
	logic [CW-1:0]         last_ext;
	logic [TIMER_BITS-1:0] sc_inc;
	logic [TIMER_BITS-1:0] ck_inc;
	logic [TIMER_BITS-1:0] hold_inc;

	// Saturating tick counters.
	assign sc_inc   = (&since_change_q) ? since_change_q : since_change_q + TIMER_BITS'(1);
	assign ck_inc   = (&since_click_q) ? since_click_q : since_click_q + TIMER_BITS'(1);
	assign hold_inc = (!stable_q && !(&hold_q)) ? hold_q + TIMER_BITS'(1) : hold_q;

	assign sc_inc_ext = CW'(sc_inc);
	assign ck_inc_ext = CW'(ck_inc);
	assign need       = (cfg.clicks_needed == 4'd0) ? 4'd1 : cfg.clicks_needed;

	// Debounce, release, click, multi-click and long-press update.
	always_comb begin
		stable_nx       = stable_q;
		since_change_nx = sc_inc;
		hold_nx         = hold_inc;
		last_hold_nx    = last_hold_q;
		since_click_nx  = ck_inc;
		clicks_nx       = clicks_q;
		long_done_nx    = long_done_q;
		rel_nx          = 1'b0;
		lp_nx           = 1'b0;
		mc_nx           = 1'b0;

		if ((level_s1 != stable_q) && (sc_inc_ext > CW'(cfg.debounce_ms))) begin
			since_change_nx = '0;
			stable_nx       = level_s1;
			if (!level_s1) begin
				hold_nx      = '0;
				long_done_nx = 1'b0;
			end else begin
				last_hold_nx = hold_inc;
				rel_nx       = 1'b1;
				if (CW'(hold_inc) < CW'(cfg.short_press_limit_ms)) begin
					if (ck_inc_ext < CW'(cfg.click_window_ms)) begin
						if (clicks_q < bdcc_pkg::CLICKS_MAX) begin
							clicks_nx = clicks_q + 4'd1;
						end
					end else begin
						clicks_nx = 4'd1;
					end
					since_click_nx = '0;
				end else begin
					clicks_nx = 4'd0;
				end
			end
		end

		if (clicks_nx >= need) begin
			mc_nx     = 1'b1;
			clicks_nx = 4'd0;
		end

		if (!stable_nx && !long_done_nx && (CW'(hold_nx) >= CW'(cfg.long_press_ms))) begin
			long_done_nx = 1'b1;
			lp_nx        = 1'b1;
		end
	end

	assign hold_ext = CW'(hold_nx);
	assign last_ext = CW'(last_hold_nx);

	// State update, once per tick moved into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q       <= 1'b1;
			since_change_q <= '0;
			hold_q         <= '0;
			last_hold_q    <= '0;
			since_click_q  <= '1;
			clicks_q       <= 4'd0;
			long_done_q    <= 1'b0;
		end else if (adv_s1) begin
			stable_q       <= stable_nx;
			since_change_q <= since_change_nx;
			hold_q         <= hold_nx;
			last_hold_q    <= last_hold_nx;
			since_click_q  <= since_click_nx;
			clicks_q       <= clicks_nx;
			long_done_q    <= long_done_nx;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	logic        pressed_q;
	logic [15:0] held_q;
	logic        rel_q;
	logic [15:0] rel_held_q;
	logic        lp_q;
	logic        mc_q;
	logic [3:0]  count_q;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			pressed_q  <= !stable_nx;
			held_q     <= stable_nx ? last_ext[15:0] : hold_ext[15:0];
			rel_q      <= rel_nx;
			rel_held_q <= rel_nx ? last_ext[15:0] : 16'd0;
			lp_q       <= lp_nx;
			mc_q       <= mc_nx;
			count_q    <= clicks_nx;
		end
	end

	assign out_valid       = out_valid_q;
	assign pressed         = pressed_q;
	assign held_ms         = held_q;
	assign release_event   = rel_q;
	assign release_held_ms = rel_held_q;
	assign long_press      = lp_q;
	assign multi_click     = mc_q;
	assign click_count     = count_q;

	// Checks on result consistency and the state update.
	`BDCC_ASSERT_NOW(a_rel_released, out_valid_q && rel_q, !pressed_q && (rel_held_q == held_q))
	`BDCC_ASSERT_NOW(a_long_pressed, out_valid_q && lp_q, pressed_q && !rel_q)
	`BDCC_ASSERT_NOW(a_mc_clears, out_valid_q && mc_q, count_q == 4'd0)
	`BDCC_ASSERT_NEXT(a_result_state, adv_s1, out_valid_q && (pressed_q == !stable_q))
	`BDCC_ASSERT_NEXT(a_state_holds, !adv_s1, $stable(clicks_q) && $stable(stable_q))

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce click classifier testbench
// Streams millisecond ticks of raw button level into the classifier while the
// result side stalls at random, and checks every result against an in-bench
// model of debounce, hold timing, click counting and the long-press and
// multi-click pulses. Settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;

	// One result transaction, in port order.
	typedef struct packed {
		logic        pressed;
		logic [15:0] held;
		logic        rel;
		logic [15:0] rel_ms;
		logic        lp;
		logic        mc;
		logic [3:0]  cnt;
	} tick_report_t;

	typedef enum {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           cfg_we = 1'b0;
	logic [bdcc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bdcc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           pin_level = 1'b1;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic                           pressed;
	logic [15:0]                    held_ms;
	logic                           release_event;
	logic [15:0]                    release_held_ms;
	logic                           long_press;
	logic                           multi_click;
	logic [3:0]                     click_count;

	// Shadow of the register file and of the classifier state.
	bdcc_pkg::cfg_t cfg_shadow = '{bdcc_pkg::DEBOUNCE_RST, bdcc_pkg::SHORT_LIMIT_RST,
	                               bdcc_pkg::CLICK_WIN_RST, bdcc_pkg::LONG_PRESS_RST,
	                               bdcc_pkg::CLICKS_NEED_RST};
	logic        db_level = 1'b1;
	logic [15:0] since_edge = '0;
	logic [15:0] hold_count = '0;
	logic [15:0] prev_hold = '0;
	logic [15:0] since_last_click = '1;
	logic [3:0]  click_tally = '0;
	logic        long_fired = 1'b0;

	tick_report_t tick_reports_q[$];
	int          failures = 0;
	int          ticks_sent = 0;
	int          burst_left = 0;
	int          hold_left = 0;
	int          stall_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	logic        hold_request = 1'b0;

	button_debounce_click_classifier dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.pin_level       (pin_level),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pressed         (pressed),
		.held_ms         (held_ms),
		.release_event   (release_event),
		.release_held_ms (release_held_ms),
		.long_press      (long_press),
		.multi_click     (multi_click),
		.click_count     (click_count)
	);

	// Clock generation, 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [15:0] sat_inc(input logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Advances the classifier state by one tick and returns the result it gives.
	function automatic tick_report_t classify_tick(input logic lvl);
		tick_report_t r;
		logic [3:0]   need;
		r = '0;
		since_edge = sat_inc(since_edge);
		since_last_click = sat_inc(since_last_click);
		if (!db_level) begin
			hold_count = sat_inc(hold_count);
		end
		// A level change is taken only once the debounce time has passed.
		if (lvl != db_level && since_edge > 16'(cfg_shadow.debounce_ms)) begin
			since_edge = '0;
			db_level = lvl;
			if (!lvl) begin
				hold_count = '0;
				long_fired = 1'b0;
			end else begin
				prev_hold = hold_count;
				r.rel = 1'b1;
				r.rel_ms = prev_hold;
				if (prev_hold < cfg_shadow.short_press_limit_ms) begin
					if (since_last_click < cfg_shadow.click_window_ms) begin
						if (click_tally != bdcc_pkg::CLICKS_MAX) begin
							click_tally++;
						end
					end else begin
						click_tally = 4'd1;
					end
					since_last_click = '0;
				end else begin
					click_tally = '0;
				end
			end
		end
		// A zero target acts as a target of one.
		need = (cfg_shadow.clicks_needed == '0) ? 4'd1 : cfg_shadow.clicks_needed;
		if (click_tally >= need) begin
			r.mc = 1'b1;
			click_tally = '0;
		end
		if (!db_level && !long_fired && hold_count >= cfg_shadow.long_press_ms) begin
			long_fired = 1'b1;
			r.lp = 1'b1;
		end
		r.pressed = !db_level;
		r.held = db_level ? prev_hold : hold_count;
		r.cnt = click_tally;
		return r;
	endfunction

	function automatic string show_tick(input tick_report_t r);
		return $sformatf("pressed=%0d held=%0d rel=%0d rel_ms=%0d long=%0d multi=%0d count=%0d",
			r.pressed, r.held, r.rel, r.rel_ms, r.lp, r.mc, r.cnt);
	endfunction

	// Offers one tick; the sender works in bursts with random gaps between them.
	task automatic send_tick(input logic lvl);
		int   gap;
		logic stalled;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		pin_level <= lvl;
		do begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
		end while (stalled);
		tick_reports_q.push_back(classify_tick(lvl));
		ticks_sent++;
	endtask

	task automatic send_noise(input int n);
		repeat (n) send_tick(1'($urandom_range(0, 1)));
	endtask

	// One press: contact bounce, a hold, more bounce, then the released rest.
	task automatic press_cycle(input int hold_len, input int rest_len);
		send_noise($urandom_range(0, 3));
		repeat (hold_len) send_tick(1'b0);
		send_noise($urandom_range(0, 3));
		repeat (rest_len) send_tick(1'b1);
	endtask

	// Stops offering ticks and waits until every result has come back.
	task automatic drain_block();
		in_valid <= 1'b0;
		while (tick_reports_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [bdcc_pkg::CFG_IDX_W-1:0] idx,
			input logic [bdcc_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			bdcc_pkg::REG_DEBOUNCE: cfg_shadow.debounce_ms = data[7:0];
			bdcc_pkg::REG_SHORT_LIMIT: cfg_shadow.short_press_limit_ms = data;
			bdcc_pkg::REG_CLICK_WIN: cfg_shadow.click_window_ms = data;
			bdcc_pkg::REG_LONG_PRESS: cfg_shadow.long_press_ms = data;
			bdcc_pkg::REG_CLICKS_NEED: cfg_shadow.clicks_needed = data[3:0];
			default: ;
		endcase
	endtask

	// Writes all registers; unused upper bits of the narrow ones carry noise.
	task automatic apply_settings(input logic [7:0] deb, input logic [15:0] short_lim,
			input logic [15:0] win, input logic [15:0] long_ms, input logic [3:0] need);
		write_reg(bdcc_pkg::REG_DEBOUNCE, {8'($urandom), deb});
		write_reg(bdcc_pkg::REG_SHORT_LIMIT, short_lim);
		write_reg(bdcc_pkg::REG_CLICK_WIN, win);
		write_reg(bdcc_pkg::REG_LONG_PRESS, long_ms);
		write_reg(bdcc_pkg::REG_CLICKS_NEED, {12'($urandom), need});
	endtask

	// Right after reset the debounce time has not passed, so nothing is taken.
	task automatic test_reset_debounce();
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		drain_block();
	endtask

	// Zero and full-scale settings with every toggle accepted.
	task automatic test_boundary_settings();
		// Long press zero fires on acceptance; a zero short limit allows no click.
		apply_settings(8'd0, 16'd0, 16'hFFFF, 16'd0, 4'd0);
		send_tick(1'b0);
		send_tick(1'b1);
		drain_block();
		// A zero click target behaves like one.
		apply_settings(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd0);
		send_tick(1'b0);
		send_tick(1'b1);
		drain_block();
		// The smallest window restarts the sequence on every click.
		apply_settings(8'd0, 16'hFFFF, 16'd1, 16'hFFFF, 4'd15);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b1);
		drain_block();
		// A short click followed by a hold past the short limit.
		apply_settings(8'd0, 16'd2, 16'hFFFF, 16'd2, 4'd2);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		drain_block();
	endtask

	// Unknown indexes are ignored and upper data bits are dropped.
	task automatic test_register_decode();
		for (int i = bdcc_pkg::REG_CLICKS_NEED + 1; i < (1 << bdcc_pkg::CFG_IDX_W); i++) begin
			write_reg(bdcc_pkg::CFG_IDX_W'(i), '1);
		end
		write_reg(bdcc_pkg::REG_DEBOUNCE, 16'hFF00);
		send_tick(1'b0);
		send_tick(1'b1);
		drain_block();
	endtask

	// Phases of random settings, each driven mostly with well-formed presses.
	task automatic test_random_phases();
		int          start_count;
		int          phase_start;
		int          budget;
		int          deb;
		logic [15:0] short_lim;
		logic [15:0] win;
		logic [15:0] long_ms;
		logic [3:0]  need;
		start_count = ticks_sent;
		while (ticks_sent - start_count < 350) begin
			deb = ($urandom_range(0, 4) < 3) ? $urandom_range(0, 3) : $urandom_range(4, 20);
			case ($urandom_range(0, 9))
				0: short_lim = '0;
				1: short_lim = '1;
				2: short_lim = 16'($urandom);
				default: short_lim = 16'($urandom_range(1, 40));
			endcase
			case ($urandom_range(0, 9))
				0: win = '1;
				1: win = 16'($urandom);
				2: win = 16'd1;
				default: win = 16'($urandom_range(2, 90));
			endcase
			case ($urandom_range(0, 9))
				0: long_ms = '0;
				1: long_ms = '1;
				2: long_ms = 16'($urandom);
				default: long_ms = 16'($urandom_range(1, 70));
			endcase
			need = ($urandom_range(0, 2) == 0) ? 4'($urandom_range(0, 15))
				: 4'($urandom_range(1, 4));
			apply_settings(8'(deb), short_lim, win, long_ms, need);
			if ($urandom_range(0, 3) == 0) begin
				write_reg(bdcc_pkg::CFG_IDX_W'($urandom_range(bdcc_pkg::REG_CLICKS_NEED + 1,
					(1 << bdcc_pkg::CFG_IDX_W) - 1)), bdcc_pkg::CFG_DATA_W'($urandom));
			end
			budget = $urandom_range(80, 200);
			phase_start = ticks_sent;
			while (ticks_sent - phase_start < budget) begin
				if ($urandom_range(0, 9) == 0) begin
					send_noise($urandom_range(1, 10));
				end else begin
					case ($urandom_range(0, 3))
						0: press_cycle($urandom_range(1, deb + 2),
							deb + 1 + $urandom_range(0, 40));
						3: press_cycle(deb + 1 + $urandom_range(30, 80),
							deb + 1 + $urandom_range(0, 40));
						default: press_cycle(deb + 1 + $urandom_range(0, 30),
							$urandom_range(1, deb + 1 + $urandom_range(0, 40)));
					endcase
				end
			end
			drain_block();
		end
	endtask

	// Largest debounce time with one long press that also counts as a click.
	task automatic test_slow_debounce();
		apply_settings(8'd255, 16'd400, 16'hFFFF, 16'd200, 4'd1);
		press_cycle(300, 300);
		drain_block();
	endtask

	// The receiver holds off for a long stretch while ticks keep coming.
	task automatic test_backpressure();
		apply_settings(8'd3, 16'd20, 16'd50, 16'd30, 4'd2);
		@(negedge clk);
		hold_request = 1'b1;
		@(posedge clk);
		repeat (6) press_cycle($urandom_range(4, 40), $urandom_range(4, 30));
		drain_block();
	endtask

	// Receiver stall pattern, with an occasional long hold-off on request.
	always @(posedge clk) begin
		if (hold_request) begin
			hold_left = 300;
			hold_request = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			if (stall_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 2));
				stall_left = $urandom_range(16, 128);
			end
			stall_left--;
			case (stall_mode)
				STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
				STALL_PERIODIC: out_stall <= (stall_left % 3 == 0);
				default: out_stall <= 1'b0;
			endcase
		end
	end

	// Result checking; a transaction seen here completes at the next rising edge.
	always @(negedge clk) begin
		tick_report_t got;
		tick_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {pressed, held_ms, release_event, release_held_ms, long_press,
				multi_click, click_count};
			if (tick_reports_q.size() == 0) begin
				failures++;
				if (failures <= 10) begin
					$display("unexpected result at %0t: %s", $time, show_tick(got));
				end
			end else begin
				want = tick_reports_q.pop_front();
				if (got !== want) begin
					failures++;
					if (failures <= 10) begin
						$display("mismatch at %0t: expected %s, got %s", $time,
							show_tick(want), show_tick(got));
					end
				end
			end
		end
	end

	// Test sequence.
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_debounce();
		test_boundary_settings();
		test_register_decode();
		test_random_phases();
		test_slow_debounce();
		test_backpressure();
		drain_block();
		repeat (10) @(posedge clk);
		if (failures == 0 && tick_reports_q.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#2_000_000;
		$display("testbench: FAIL");
		$finish;
	end

endmodule
